// File: sv/atpr_pkg.sv
// Shared types, widths and the CORDIC arctangent table for the tilt block.
package atpr_pkg;

	// Fractional bits of degrees carried by the CORDIC angle accumulator (12..24).
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int TABLE_FRAC      = 24;
	localparam int ROOT_SCALE      = 15;
	localparam int CORDIC_STEPS    = ANGLE_FRAC_BITS + 4;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int SQ_W     = 32;
	localparam int ROOT_W   = 31;
	localparam int ROOT_STAGES = ROOT_W;
	localparam int REM_W    = 32;
	localparam int XY_W     = 36;
	localparam int ACC_W    = ANGLE_FRAC_BITS + 9;
	localparam int DEG_W    = 8;
	localparam int DEG_MAG_W = 7;

	localparam logic [DEG_MAG_W-1:0] DEG_RIGHT = 7'd90;
	localparam logic signed [ACC_W-1:0] ANGLE_TOP = ACC_W'(90 * (1 << ANGLE_FRAC_BITS));

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// atan(2^-i) in degrees, scaled by 2^24.
	localparam int ATAN_DEG_Q24 [32] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
		14, 7, 4, 2, 1, 0
	};

	// Per-lane side information that travels with each operand pair.
	typedef struct packed {
		logic             num_zero;
		logic             den_zero;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} lane_tag_t;

	// One queued transaction: both sums of squares and both lane tags.
	typedef struct packed {
		logic [SQ_W-1:0] sq_p;
		logic [SQ_W-1:0] sq_r;
		lane_tag_t       tag_p;
		lane_tag_t       tag_r;
	} q_entry_t;

	// Table entry rounded from Q24 to the accumulator's fractional bits.
	function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
		int     sh;
		longint t;
		sh = TABLE_FRAC - ANGLE_FRAC_BITS;
		t = longint'(ATAN_DEG_Q24[idx % 32]);
		if (sh != 0) begin
			t = (t + (longint'(1) << (sh - 1))) >>> sh;
		end
		return ACC_W'(t);
	endfunction

endpackage

// File: sv/atpr_front.sv
// Front end: accepts samples, forms magnitudes, squares and sums, and classifies lanes.
module atpr_front import atpr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SAMPLE_W-1:0] accel_x,
	input  logic signed [SAMPLE_W-1:0] accel_y,
	input  logic signed [SAMPLE_W-1:0] accel_z,
	input  logic [QCNT_W-1:0]          q_count,
	output logic                       busy,
	output logic                       push,
	output q_entry_t                   push_entry
);

	function automatic logic [MAG_W-1:0] abs_val(input logic signed [SAMPLE_W-1:0] v);
		logic signed [MAG_W-1:0] e;
		e = MAG_W'(v);
		return e[MAG_W-1] ? MAG_W'(-e) : MAG_W'(e);
	endfunction

	logic             accept;
	logic             vld_s1, vld_s2;
	logic [MAG_W-1:0] mag_x_s1, mag_y_s1, mag_z_s1;
	logic             neg_x_s1, neg_y_s1;
	logic [MAG_W-1:0] mag_x_s2, mag_y_s2;
	logic             neg_x_s2, neg_y_s2;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2, sqz_s2;
	logic [2*MAG_W-1:0] prod_x, prod_y, prod_z;
	logic [SQ_W-1:0]  sum_p, sum_r;
	logic [QCNT_W-1:0] in_flight;

	// Credit check: queued entries plus those still in the front stages.
	assign in_flight = q_count + QCNT_W'(vld_s1) + QCNT_W'(vld_s2);
	assign busy      = (in_flight >= QCNT_W'(QUEUE_DEPTH));
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	assign prod_x = {MAG_W'(0), mag_x_s1} * {MAG_W'(0), mag_x_s1};
	assign prod_y = {MAG_W'(0), mag_y_s1} * {MAG_W'(0), mag_y_s1};
	assign prod_z = {MAG_W'(0), mag_z_s1} * {MAG_W'(0), mag_z_s1};

	always_ff @(posedge clk) begin
		mag_x_s1 <= abs_val(accel_x);
		mag_y_s1 <= abs_val(accel_y);
		mag_z_s1 <= abs_val(accel_z);
		neg_x_s1 <= accel_x[SAMPLE_W-1];
		neg_y_s1 <= accel_y[SAMPLE_W-1];
		sqx_s2   <= SQ_W'(prod_x);
		sqy_s2   <= SQ_W'(prod_y);
		sqz_s2   <= SQ_W'(prod_z);
		mag_x_s2 <= mag_x_s1;
		mag_y_s2 <= mag_y_s1;
		neg_x_s2 <= neg_x_s1;
		neg_y_s2 <= neg_y_s1;
	end

	assign sum_p = sqy_s2 + sqz_s2;
	assign sum_r = sqx_s2 + sqz_s2;

	assign push = vld_s2;

	always_comb begin
		push_entry.sq_p           = sum_p;
		push_entry.sq_r           = sum_r;
		push_entry.tag_p.num_zero = (mag_x_s2 == '0);
		push_entry.tag_p.den_zero = (sum_p == '0);
		push_entry.tag_p.neg      = neg_x_s2;
		push_entry.tag_p.mag      = mag_x_s2;
		push_entry.tag_r.num_zero = (mag_y_s2 == '0);
		push_entry.tag_r.den_zero = (sum_r == '0);
		push_entry.tag_r.neg      = neg_y_s2;
		push_entry.tag_r.mag      = mag_y_s2;
	end

endmodule

// File: sv/atpr_queue.sv
// Short register queue that decouples the front end from the root and CORDIC lanes.
module atpr_queue import atpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  q_entry_t          in_entry,
	input  logic              pop,
	output logic              out_valid,
	output q_entry_t          out_entry,
	output logic [QCNT_W-1:0] count
);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_entry;
		end
	end

	assign out_valid = (count_q != '0);
	assign out_entry = mem_q[rd_ptr_q];
	assign count     = count_q;

endmodule

// File: sv/atpr_isqrt.sv
// Pipelined integer square root of the sum of squares scaled by 2^30, one root bit per stage.
module atpr_isqrt import atpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   in_sq,
	input  lane_tag_t         in_tag,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output lane_tag_t         out_tag
);

	logic              vld_s  [1:ROOT_STAGES];
	logic [REM_W-1:0]  rem_s  [1:ROOT_STAGES];
	logic [ROOT_W-1:0] root_s [1:ROOT_STAGES];
	logic [SQ_W-1:0]   sq_s   [1:ROOT_STAGES];
	lane_tag_t         tag_s  [1:ROOT_STAGES];

	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
		localparam int HI = SQ_W - 1 - 2 * k;
		logic              cur_vld;
		logic [REM_W-1:0]  cur_rem;
		logic [ROOT_W-1:0] cur_root;
		logic [SQ_W-1:0]   cur_sq;
		lane_tag_t         cur_tag;
		logic [1:0]        pair;
		logic [REM_W+1:0]  trial, test;
		logic              fits;

		if (k == 0) begin : g_first
			assign cur_vld  = in_valid;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_sq   = in_sq;
			assign cur_tag  = in_tag;
		end else begin : g_next
			assign cur_vld  = vld_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_sq   = sq_s[k];
			assign cur_tag  = tag_s[k];
		end

		// The low 30 bits of the scaled radicand are zero, so late stages bring in zero pairs.
		if (HI >= 1) begin : g_pair
			assign pair = cur_sq[HI -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign trial = {cur_rem, pair};
		assign test  = {1'b0, cur_root, 2'b01};
		assign fits  = (trial >= test);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= fits ? REM_W'(trial - test) : REM_W'(trial);
			root_s[k+1] <= {cur_root[ROOT_W-2:0], fits};
			sq_s[k+1]   <= cur_sq;
			tag_s[k+1]  <= cur_tag;
		end
	end

	assign out_valid = vld_s[ROOT_STAGES];
	assign out_root  = root_s[ROOT_STAGES];
	assign out_tag   = tag_s[ROOT_STAGES];

endmodule

// File: sv/atpr_cordic.sv
// Pipelined vectoring CORDIC in degrees, with clamping, special cases and sign on the last stage.
module atpr_cordic import atpr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [ROOT_W-1:0]       in_root,
	input  lane_tag_t               in_tag,
	output logic                    out_valid,
	output logic signed [DEG_W-1:0] out_deg
);

	logic                    vld_s [1:CORDIC_STEPS];
	logic signed [XY_W-1:0]  vx_s  [1:CORDIC_STEPS];
	logic signed [XY_W-1:0]  vy_s  [1:CORDIC_STEPS];
	logic signed [ACC_W-1:0] acc_s [1:CORDIC_STEPS];
	lane_tag_t               tag_s [1:CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [ACC_W-1:0] ENTRY = atan_entry(i);
		logic                    cur_vld;
		logic signed [XY_W-1:0]  cur_vx, cur_vy, dx, dy;
		logic signed [ACC_W-1:0] cur_acc;
		lane_tag_t               cur_tag;
		logic                    up;

		if (i == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_vx  = $signed(XY_W'(in_root));
			assign cur_vy  = $signed(XY_W'(in_tag.mag)) <<< ROOT_SCALE;
			assign cur_acc = '0;
			assign cur_tag = in_tag;
		end else begin : g_next
			assign cur_vld = vld_s[i];
			assign cur_vx  = vx_s[i];
			assign cur_vy  = vy_s[i];
			assign cur_acc = acc_s[i];
			assign cur_tag = tag_s[i];
		end

		assign dx = cur_vy >>> i;
		assign dy = cur_vx >>> i;
		assign up = !cur_vy[XY_W-1] && (cur_vy != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			vx_s[i+1]  <= up ? cur_vx + dx : cur_vx - dx;
			vy_s[i+1]  <= up ? cur_vy - dy : cur_vy + dy;
			acc_s[i+1] <= up ? cur_acc + ENTRY : cur_acc - ENTRY;
			tag_s[i+1] <= cur_tag;
		end
	end

	logic signed [ACC_W-1:0] acc_f;
	lane_tag_t               tag_f;
	logic [DEG_MAG_W-1:0]    deg_clamped, deg_abs;
	logic signed [DEG_W-1:0] deg_signed;
	logic                    out_vld_q;
	logic signed [DEG_W-1:0] out_deg_q;

	assign acc_f = acc_s[CORDIC_STEPS];
	assign tag_f = tag_s[CORDIC_STEPS];

	always_comb begin
		priority if (acc_f[ACC_W-1]) begin
			deg_clamped = '0;
		end else if (acc_f > ANGLE_TOP) begin
			deg_clamped = DEG_RIGHT;
		end else begin
			deg_clamped = acc_f[ANGLE_FRAC_BITS +: DEG_MAG_W];
		end

		// A zero numerator wins over a zero denominator.
		priority if (tag_f.num_zero) begin
			deg_abs = '0;
		end else if (tag_f.den_zero) begin
			deg_abs = DEG_RIGHT;
		end else begin
			deg_abs = deg_clamped;
		end

		deg_signed = tag_f.neg ? -$signed({1'b0, deg_abs}) : $signed({1'b0, deg_abs});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		out_deg_q <= deg_signed;
	end

	assign out_valid = out_vld_q;
	assign out_deg   = out_deg_q;

endmodule

// File: sv/accel_tilt_pitch_roll_top.sv
// Top level of the accelerometer tilt block: pitch and roll in whole degrees from one sample.
//
// A transaction is accepted at a rising clock edge where start is high and busy is low; each
// transaction yields exactly one result, shown on pitch_deg and roll_deg for one clock cycle
// while done is high. The receiver cannot stall, so done and the angles must be captured in
// that cycle. The block takes a new sample every clock cycle: the front end, the root lanes and
// the CORDIC lanes are fully pipelined, and busy only rises if the queue's credit runs out,
// which does not happen in steady use because the back end drains one entry per cycle.
// Results come out in acceptance order, after passing through two front stages, the queue
// register, the 31-stage square-root pipeline, ANGLE_FRAC_BITS + 4 CORDIC stages and the
// output register.
// The front end takes magnitudes, squares them and forms y^2+z^2 (pitch) and x^2+z^2 (roll),
// tagging each lane with zero-numerator and zero-denominator flags. Each lane then takes the
// integer root of its sum scaled by 2^30 and runs a vectoring CORDIC on (root, |num| * 2^15).
// The angle is clamped to 0..90 degrees, truncated, and given the numerator's sign. A zero
// numerator gives 0 degrees and a zero denominator with a nonzero numerator gives +/-90.
module accel_tilt_pitch_roll_top import atpr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [SAMPLE_W-1:0] accel_x,
	input  logic signed [SAMPLE_W-1:0] accel_y,
	input  logic signed [SAMPLE_W-1:0] accel_z,
	output logic                       done,
	output logic signed [DEG_W-1:0]    pitch_deg,
	output logic signed [DEG_W-1:0]    roll_deg
);

	logic              push;
	q_entry_t          push_entry;
	logic              q_valid;
	q_entry_t          q_entry;
	logic [QCNT_W-1:0] q_count;

	logic              root_p_valid, root_r_valid;
	logic [ROOT_W-1:0] root_p, root_r;
	lane_tag_t         root_p_tag, root_r_tag;
	logic              done_p, done_r;

	atpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.q_count    (q_count),
		.busy       (busy),
		.push       (push),
		.push_entry (push_entry)
	);

	// The back end never stalls, so the queue head is taken whenever it is present.
	atpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_entry  (push_entry),
		.pop       (q_valid),
		.out_valid (q_valid),
		.out_entry (q_entry),
		.count     (q_count)
	);

	// Pitch lane: numerator x, denominator sqrt(y^2 + z^2).
	atpr_isqrt u_isqrt_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_sq     (q_entry.sq_p),
		.in_tag    (q_entry.tag_p),
		.out_valid (root_p_valid),
		.out_root  (root_p),
		.out_tag   (root_p_tag)
	);

	atpr_cordic u_cordic_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_p_valid),
		.in_root   (root_p),
		.in_tag    (root_p_tag),
		.out_valid (done_p),
		.out_deg   (pitch_deg)
	);

	// Roll lane: numerator y, denominator sqrt(x^2 + z^2). It runs in lockstep with pitch.
	atpr_isqrt u_isqrt_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_sq     (q_entry.sq_r),
		.in_tag    (q_entry.tag_r),
		.out_valid (root_r_valid),
		.out_root  (root_r),
		.out_tag   (root_r_tag)
	);

	atpr_cordic u_cordic_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_r_valid),
		.in_root   (root_r),
		.in_tag    (root_r_tag),
		.out_valid (done_r),
		.out_deg   (roll_deg)
	);

	// Both lanes finish in the same cycle, so the result strobe is their common valid.
	assign done = done_p && done_r;

endmodule
